// ===== hdl/htbp_pkg.sv =====
package htbp_pkg;

  localparam int BYTE_BITS = 8;
  localparam int CODE_W    = 32;
  localparam int COUNT_W   = 48;
  localparam int OP_W      = 2;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_ENCODE = 2'd1;
  localparam op_t OP_FLUSH  = 2'd2;

endpackage

// ===== hdl/huffman_table_bit_packer.sv =====
// Static-table Huffman bit packer. A load item writes one entry (code word and
// length) of the code table; an encode item looks up its byte's code and appends
// the code's bits, MSB first, to a bit accumulator; every completed byte leaves as
// one result, earliest bit in bit 7, with a running byte count for the file. A
// flush item zero-pads and emits any partial byte, then clears the accumulator and
// the count. The table sits in a synchronous memory read at item acceptance;
// per-entry valid flops make unwritten entries read as length 0, so no clearing
// pass is needed after reset. Rate: one item per cycle while codes complete at
// most one byte and the output is not stalled. An item whose code completes k
// bytes emits one byte per cycle through the output register while the output
// is ready and holds the next item until its last full byte has been emitted
// (k is at most (MAX_CODE_BITS+7)/8). Results pass the stage 1 and output registers.
module huffman_table_bit_packer #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [htbp_pkg::OP_W-1:0]     operation,
  input  logic [7:0]                    symbol,
  input  logic [htbp_pkg::CODE_W-1:0]   code_bits,
  input  logic [5:0]                    code_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic [htbp_pkg::COUNT_W-1:0]  bytes_so_far,
  output logic                          last_of_run
);
  import htbp_pkg::*;

  localparam int AB = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int CW = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int AW = MAX_CODE_BITS + BYTE_BITS - 1;
  localparam int NW = $clog2(AW + 1);

  // code table
  logic [LW+CW-1:0]       mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;

  logic          in_fire;
  logic          in_range;
  logic [AB-1:0] sym_idx;
  logic [LW-1:0] len_sat;
  logic [CW-1:0] wr_code;

  // stage 1: item with its table entry
  logic          s1_valid;
  op_t           s1_op;
  logic          s1_hit;
  logic [LW+CW-1:0] rd_entry;

  // accumulator, left aligned: valid bits at the top
  logic [AW-1:0]      acc;
  logic [NW-1:0]      acnt;
  logic [COUNT_W-1:0] count;

  logic          is_enc;
  logic          is_flush;
  logic          use_code;
  logic [NW-1:0] len_n;
  logic [AW-1:0] code_ext;
  logic [NW-1:0] sh;
  logic [AW-1:0] merged;
  logic [NW-1:0] cnt_m;
  logic          draining;
  logic          slot_free;
  logic          need_out;
  logic          consume;
  logic          emit;
  logic [AW-1:0] src_acc;
  logic [NW-1:0] src_cnt;
  logic          last_next;
  logic [COUNT_W-1:0] count_inc;

  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
  assign sym_idx  = symbol[AB-1:0];

  always_comb begin
    if ({1'b0, code_length} > 7'(MAX_CODE_BITS)) begin
      len_sat = LW'(MAX_CODE_BITS);
    end else begin
      len_sat = LW'(code_length);
    end
    for (int i = 0; i < CW; i++) begin
      wr_code[i] = code_bits[i] && (i < int'(len_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && operation == OP_LOAD && in_range) begin
      mem[sym_idx] <= {len_sat, wr_code};
    end
    if (in_fire) begin
      rd_entry <= mem[sym_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (in_fire && operation == OP_LOAD && in_range) begin
      vld[sym_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op  <= operation;
      s1_hit <= in_range && vld[sym_idx];
    end
  end

  assign is_enc   = s1_op == OP_ENCODE;
  assign is_flush = s1_op == OP_FLUSH;
  assign use_code = is_enc && s1_hit;

  always_comb begin
    len_n    = use_code ? NW'(rd_entry[LW+CW-1:CW]) : '0;
    code_ext = use_code ? AW'(rd_entry[CW-1:0]) : '0;
    sh       = NW'(AW) - acnt - len_n;
    merged   = acc | (code_ext << sh);
    cnt_m    = acnt + len_n;
  end

  assign draining  = acnt >= NW'(BYTE_BITS);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    need_out = 1'b0;
    if (is_enc) begin
      need_out = cnt_m >= NW'(BYTE_BITS);
    end else if (is_flush) begin
      need_out = acnt != '0;
    end
  end

  assign consume   = s1_valid && !draining && (!need_out || slot_free);
  assign emit      = (draining && slot_free) || (consume && need_out);
  assign src_acc   = draining ? acc : merged;
  assign src_cnt   = draining ? acnt : cnt_m;
  assign last_next = {1'b0, src_cnt} < (NW+1)'(2 * BYTE_BITS);
  assign count_inc = count + 1'b1;
  assign in_ready  = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
      acnt     <= '0;
      count    <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (consume) begin
        s1_valid <= 1'b0;
      end

      if (consume && is_flush) begin
        acc   <= '0;
        acnt  <= '0;
        count <= '0;
      end else if (emit) begin
        acc   <= src_acc << BYTE_BITS;
        acnt  <= src_cnt - NW'(BYTE_BITS);
        count <= count_inc;
      end else if (consume && is_enc) begin
        acc  <= merged;
        acnt <= cnt_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte     <= src_acc[AW-1 -: BYTE_BITS];
      bytes_so_far <= count_inc;
      last_of_run  <= last_next;
    end
  end

  // bits below the filled part of the accumulator stay clear
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc << acnt) == '0)
    else $error("accumulator holds bits below its fill level");

  // no new item merges while a full byte still waits
  a_no_merge_drain: assert property (@(posedge clk) disable iff (rst)
    draining |-> !consume)
    else $error("item consumed while accumulator drains");

  // a byte that is not last leaves at least one more full byte behind
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    emit && !last_next |=> acnt >= NW'(BYTE_BITS))
    else $error("non-last byte without a following byte");

  // a flush leaves an empty accumulator and a zero count
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    consume && is_flush |=> acnt == '0 && count == '0)
    else $error("flush did not clear state");

endmodule

// ===== dv/tb_huffman_table_bit_packer.sv =====
`timescale 1ns / 100ps

typedef struct {
  logic [7:0]                   data;
  logic [htbp_pkg::COUNT_W-1:0] count;
  logic                         last;
} packed_byte_t;

class packer_scoreboard;
  localparam int TABLE_SIZE = 256;
  localparam int MAX_LEN    = 32;
  localparam int PRINT_CAP  = 40;

  logic [htbp_pkg::CODE_W-1:0]  code_word [TABLE_SIZE];
  int                           code_len  [TABLE_SIZE];
  logic [6:0]                   acc_bits;
  int                           acc_count;
  logic [htbp_pkg::COUNT_W-1:0] byte_count;
  packed_byte_t                 expected_bytes [$];
  int                           mismatches;

  function new();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      code_word[i] = '0;
      code_len[i]  = 0;
    end
    acc_bits   = '0;
    acc_count  = 0;
    byte_count = '0;
    mismatches = 0;
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  function void push_byte(logic [7:0] data);
    packed_byte_t b;
    byte_count = byte_count + 1'b1;
    b.data  = data;
    b.count = byte_count;
    b.last  = 1'b0;
    expected_bytes.push_back(b);
  endfunction

  // Works out the bytes one accepted item should produce.
  function void note_item(htbp_pkg::op_t op, logic [7:0] sym,
                          logic [htbp_pkg::CODE_W-1:0] code, logic [5:0] len);
    int           eff_len;
    int           produced;
    logic [63:0]  mask;
    logic [7:0]   wide;
    logic         code_bit;
    packed_byte_t tail;
    produced = 0;
    case (op)
      htbp_pkg::OP_LOAD: begin
        eff_len = (len > MAX_LEN) ? MAX_LEN : int'(len);
        mask = (64'd1 << eff_len) - 64'd1;
        code_word[sym] = code & mask[htbp_pkg::CODE_W-1:0];
        code_len[sym]  = eff_len;
      end
      htbp_pkg::OP_ENCODE: begin
        for (int i = code_len[sym]; i > 0; i--) begin
          code_bit = (i - 1 < htbp_pkg::CODE_W) ? code_word[sym][i-1] : 1'b0;
          wide = {acc_bits, code_bit};
          acc_count++;
          if (acc_count == htbp_pkg::BYTE_BITS) begin
            push_byte(wide);
            produced++;
            acc_bits  = '0;
            acc_count = 0;
          end else begin
            acc_bits = wide[6:0];
          end
        end
        if (produced > 0) begin
          tail = expected_bytes.pop_back();
          tail.last = 1'b1;
          expected_bytes.push_back(tail);
        end
      end
      htbp_pkg::OP_FLUSH: begin
        if (acc_count > 0) begin
          wide = {1'b0, acc_bits};
          wide = wide << (htbp_pkg::BYTE_BITS - acc_count);
          push_byte(wide);
          tail = expected_bytes.pop_back();
          tail.last = 1'b1;
          expected_bytes.push_back(tail);
        end
        acc_bits   = '0;
        acc_count  = 0;
        byte_count = '0;
      end
      default: ;
    endcase
  endfunction

  task check_result(logic [7:0] data, logic [htbp_pkg::COUNT_W-1:0] count, logic last);
    packed_byte_t want;
    if (expected_bytes.size() == 0) begin
      report($sformatf("unexpected byte %02h count %0d last %0b", data, count, last));
      return;
    end
    want = expected_bytes.pop_front();
    if (data !== want.data)
      report($sformatf("out_byte %02h, want %02h", data, want.data));
    if (count !== want.count)
      report($sformatf("bytes_so_far %0d, want %0d", count, want.count));
    if (last !== want.last)
      report($sformatf("last_of_run %0b, want %0b (byte %02h)", last, want.last, want.data));
  endtask
endclass

module tb_huffman_table_bit_packer;
  localparam htbp_pkg::op_t OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 80;
  localparam int DRAIN_LIMIT  = 5000;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [htbp_pkg::OP_W-1:0]    operation = '0;
  logic [7:0]                   symbol = '0;
  logic [htbp_pkg::CODE_W-1:0]  code_bits = '0;
  logic [5:0]                   code_length = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_byte;
  logic [htbp_pkg::COUNT_W-1:0] bytes_so_far;
  logic                         last_of_run;

  packer_scoreboard sb = new();
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;
  int               hold_left = 0;
  logic [7:0]       live_syms [$];

  huffman_table_bit_packer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .symbol       (symbol),
    .code_bits    (code_bits),
    .code_length  (code_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .bytes_so_far (bytes_so_far),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [5:0] pick_code_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return 6'd0;
    if (r < 50) return 6'($urandom_range(1, 8));
    if (r < 80) return 6'($urandom_range(9, 16));
    if (r < 95) return 6'($urandom_range(17, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  // Called right after an edge; returns right after the edge that takes the item.
  task automatic drive_item(htbp_pkg::op_t op, logic [7:0] sym,
                            logic [htbp_pkg::CODE_W-1:0] code, logic [5:0] len);
    int gap;
    if ($urandom_range(0, 14) == 0) in_calm = ~in_calm;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    symbol      <= sym;
    code_bits   <= code;
    code_length <= len;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, sym, code, len);
  endtask

  task automatic load_random();
    logic [7:0] sym;
    sym = 8'($urandom_range(0, 255));
    live_syms.push_back(sym);
    drive_item(htbp_pkg::OP_LOAD, sym, $urandom(), pick_code_len());
  endtask

  task automatic encode_live();
    logic [7:0] sym;
    if (live_syms.size() == 0 || $urandom_range(0, 9) == 0)
      sym = 8'($urandom_range(0, 255));
    else
      sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
    drive_item(htbp_pkg::OP_ENCODE, sym, $urandom(), 6'($urandom_range(0, 63)));
  endtask

  // Receiver: checks each accepted byte, then picks the next ready level.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(out_byte, bytes_so_far, last_of_run);
      if ($urandom_range(0, 39) == 0) out_calm = ~out_calm;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) hold_left = pick_gap(1'b0);
      end
    end
  end

  initial begin
    int sent;
    int r;
    int drain;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part
    drive_item(htbp_pkg::OP_ENCODE, 8'd0, '0, '0);           // entry never loaded
    drive_item(htbp_pkg::OP_FLUSH, 8'd0, '0, '0);            // nothing pending
    drive_item(OP_UNUSED, 8'h5A, 32'h1234_5678, 6'd9);
    drive_item(htbp_pkg::OP_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    drive_item(htbp_pkg::OP_ENCODE, 8'd255, '0, '0);         // four full bytes
    drive_item(htbp_pkg::OP_LOAD, 8'd0, 32'hA5A5_5A5A, 6'd63); // length saturates
    drive_item(htbp_pkg::OP_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd1);  // upper bits dropped
    drive_item(htbp_pkg::OP_LOAD, 8'd2, 32'hFFFF_FFFF, 6'd0);  // empty code
    drive_item(htbp_pkg::OP_ENCODE, 8'd1, '0, '0);
    drive_item(htbp_pkg::OP_ENCODE, 8'd0, '0, '0);
    drive_item(htbp_pkg::OP_ENCODE, 8'd2, '0, '0);
    drive_item(htbp_pkg::OP_FLUSH, 8'd0, '0, '0);
    drive_item(htbp_pkg::OP_LOAD, 8'd3, 32'h0000_007F, 6'd7);
    drive_item(htbp_pkg::OP_ENCODE, 8'd3, '0, '0);
    drive_item(htbp_pkg::OP_ENCODE, 8'd1, '0, '0);
    drive_item(htbp_pkg::OP_LOAD, 8'd4, 32'hFFFF_FF00, 6'd8);
    drive_item(htbp_pkg::OP_ENCODE, 8'd4, '0, '0);
    drive_item(htbp_pkg::OP_LOAD, 8'd128, 32'h8000_0001, 6'd33);
    drive_item(htbp_pkg::OP_ENCODE, 8'd3, '0, '0);
    drive_item(htbp_pkg::OP_ENCODE, 8'd128, '0, '0);
    drive_item(htbp_pkg::OP_FLUSH, 8'd0, '0, '0);
    drive_item(htbp_pkg::OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    drive_item(htbp_pkg::OP_ENCODE, 8'd255, '0, '0);         // count restarts
    drive_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    drive_item(htbp_pkg::OP_FLUSH, 8'd0, '0, '0);

    // random part: prime a working set, then files of encodes closed by a flush
    sent = 0;
    repeat (12) begin
      load_random();
      sent++;
    end
    while (sent < RANDOM_ITEMS) begin
      repeat ($urandom_range(1, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          load_random();
          sent++;
        end else if (r < 14) begin
          drive_item(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom(), pick_code_len());
        end else begin
          encode_live();
          sent++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        drive_item(htbp_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
                   6'($urandom_range(0, 63)));
        sent++;
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (sb.expected_bytes.size() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (sb.expected_bytes.size() > 0)
      sb.report($sformatf("%0d expected bytes never arrived", sb.expected_bytes.size()));

    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
